FILE: rtl/core/pism_pkg.sv
// ----------------------------------------------------------------------------
// pism_pkg
// Types, sizes and codes shared by the panel input scan and LED map block.
// ----------------------------------------------------------------------------
package pism_pkg;

    localparam int MODULES         = 16;
    localparam int ENTRIES         = 128;
    localparam int BITS_PER_MODULE = 8;
    localparam int IDX_W           = $clog2(ENTRIES);

    // command codes
    localparam logic [2:0] CMD_LOAD     = 3'd0;
    localparam logic [2:0] CMD_SCAN     = 3'd1;
    localparam logic [2:0] CMD_SET_OCC  = 3'd2;
    localparam logic [2:0] CMD_SET_ACC  = 3'd3;
    localparam logic [2:0] CMD_READ_LED = 3'd4;

    // entry kinds
    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_ACCESSORY = 2'd1;
    localparam logic [1:0] KIND_OCCUPANCY = 2'd2;
    localparam logic [1:0] KIND_ROUTE     = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  entry_index;
        logic [1:0]  entry_kind;
        logic [15:0] address;
        logic        entry_inverted;
        logic [3:0]  module_req;
        logic [7:0]  input_bits;
        logic        set_state;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] event_address;
        logic [6:0]  event_index;
        logic        event_state;
        logic [7:0]  led_bits;
        logic        last;
    } t_res;

    // one table entry as it travels around the ring
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic        inv;
        logic        lamp;
        logic        level;
    } t_entry;

endpackage

FILE: rtl/core/pism_cell.sv
// ----------------------------------------------------------------------------
// pism_cell
// One ring cell: holds a table entry and hands it on to the next cell.
// ----------------------------------------------------------------------------
module pism_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  pism_pkg::t_entry  i_entry,
    output pism_pkg::t_entry  o_entry
);

    logic [1:0]  r_kind;
    logic [15:0] r_addr;
    logic        r_inv;
    logic        r_lamp;
    logic        r_level;

    // kind, address and invert are undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_kind <= i_entry.kind;
            r_addr <= i_entry.addr;
            r_inv  <= i_entry.inv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp  <= 1'b0;
            r_level <= 1'b0;
        end else if (i_shift) begin
            r_lamp  <= i_entry.lamp;
            r_level <= i_entry.level;
        end
    end

    assign o_entry.kind  = r_kind;
    assign o_entry.addr  = r_addr;
    assign o_entry.inv   = r_inv;
    assign o_entry.lamp  = r_lamp;
    assign o_entry.level = r_level;

endmodule

FILE: rtl/core/pism_ctrl.sv
// ----------------------------------------------------------------------------
// pism_ctrl
// Ring head: walks the entry ring once per command, updates the entry at the
// head and produces the result strobes.
// ----------------------------------------------------------------------------
module pism_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pism_pkg::t_in     i_item,
    input  pism_pkg::t_entry  i_head,
    output logic              o_busy,
    output logic              o_shift,
    output pism_pkg::t_entry  o_entry,
    output logic              o_valid,
    output pism_pkg::t_res    o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [pism_pkg::IDX_W-1:0] LAST_IDX = pism_pkg::IDX_W'(pism_pkg::ENTRIES - 1);

    logic [1:0]                 r_state, n_state;
    logic [pism_pkg::IDX_W-1:0] r_cnt, n_cnt;
    pism_pkg::t_in              r_item, n_item;
    logic [7:0]                 r_led, n_led;
    logic                       r_pend_valid, n_pend_valid;
    pism_pkg::t_res             r_pend, n_pend;
    logic                       r_out_valid, n_out_valid;
    pism_pkg::t_res             r_out, n_out;

    pism_pkg::t_entry           w_entry;
    logic                       w_in_mod;
    logic                       w_bit;
    logic [2:0]                 w_pos;
    logic [1:0]                 w_set_kind;

    assign w_pos    = r_cnt[2:0];
    assign w_bit    = r_item.input_bits[w_pos];
    assign w_in_mod = ((16'(r_cnt) >> 3) == 16'(r_item.module_req)) &&
                      (16'(r_item.module_req) < 16'(pism_pkg::MODULES));
    assign w_set_kind = (r_item.cmd == pism_pkg::CMD_SET_OCC) ?
                        pism_pkg::KIND_OCCUPANCY : pism_pkg::KIND_ACCESSORY;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_item       = r_item;
        n_led        = r_led;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        w_entry      = i_head;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state      = ST_WALK;
                    n_cnt        = '0;
                    n_item       = i_item;
                    n_led        = '0;
                    n_pend_valid = 1'b0;
                end
            end
            ST_WALK: begin
                case (r_item.cmd)
                    pism_pkg::CMD_LOAD: begin
                        if (16'(r_item.entry_index) == 16'(r_cnt)) begin
                            w_entry.kind = r_item.entry_kind;
                            w_entry.addr = r_item.address;
                            w_entry.inv  = r_item.entry_inverted;
                        end
                    end
                    pism_pkg::CMD_SCAN: begin
                        if (w_in_mod && (w_bit != i_head.level)) begin
                            w_entry.level = w_bit;
                            w_entry.lamp  = w_bit;
                            if (i_head.kind != pism_pkg::KIND_NONE) begin
                                // hold each event back one find so the final one gets last
                                if (r_pend_valid) begin
                                    n_out_valid = 1'b1;
                                    n_out       = r_pend;
                                end
                                n_pend_valid         = 1'b1;
                                n_pend.event_kind    = i_head.kind;
                                n_pend.event_address = i_head.addr;
                                n_pend.event_index   = 7'(r_cnt);
                                n_pend.event_state   = w_bit;
                                n_pend.led_bits      = '0;
                                n_pend.last          = 1'b0;
                            end
                        end
                    end
                    pism_pkg::CMD_SET_OCC, pism_pkg::CMD_SET_ACC: begin
                        if ((i_head.kind == w_set_kind) && (i_head.addr == r_item.address)) begin
                            w_entry.lamp = r_item.set_state;
                        end
                    end
                    pism_pkg::CMD_READ_LED: begin
                        if (w_in_mod) begin
                            n_led[w_pos] = i_head.lamp ^ i_head.inv;
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
                if (r_item.cmd == pism_pkg::CMD_SCAN && r_pend_valid) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                end else if (r_item.cmd == pism_pkg::CMD_READ_LED) begin
                    n_out_valid         = 1'b1;
                    n_out.event_kind    = pism_pkg::KIND_NONE;
                    n_out.event_address = '0;
                    n_out.event_index   = '0;
                    n_out.event_state   = 1'b0;
                    n_out.led_bits      = r_led;
                    n_out.last          = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_led  <= n_led;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_shift  = (r_state == ST_WALK);
    assign o_entry  = w_entry;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == ST_WALK || r_state == ST_DONE))
        else $error("result strobe without a command in progress");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_cnt == LAST_IDX) |=> (r_state == ST_DONE))
        else $error("walk did not end after the last entry");

    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_WALK && r_cnt == '0))
        else $error("accepted command did not start a walk at entry zero");

    a_pend_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_state != ST_IDLE) |-> (r_item.cmd == pism_pkg::CMD_SCAN))
        else $error("pending event outside a scan");

    a_last_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> $past(r_state == ST_DONE))
        else $error("last result before the walk finished");

endmodule

FILE: rtl/core/panel_input_scan_and_led_map.sv
// ----------------------------------------------------------------------------
// panel_input_scan_and_led_map
// Control-panel I/O table kept in a ring of entry cells, with a load, scan,
// lamp set and LED read engine at the ring head.
// ----------------------------------------------------------------------------
// Every command holds busy high after the transfer at start while the whole
// entry ring rotates once past the head, one entry per cycle, and the done
// state then closes the command. A new command is taken only while busy is
// low. Results are strobed on o_valid for one cycle each and cannot be held
// off. A scan gives one result per changed input of a loaded entry of
// non-none kind, in rising bit order, at most eight; they appear during the
// walk and the final one, flagged last, in the first cycle with busy low
// again. A LED read gives one result in that same cycle. Load and set
// commands give none. Levels and lamps are zero after reset.
module panel_input_scan_and_led_map (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pism_pkg::t_in   i_item,
    output logic            o_valid,
    output pism_pkg::t_res  o_result
);

    pism_pkg::t_entry w_chain [pism_pkg::ENTRIES+1];
    logic             w_shift;

    // entry i sits in cell ENTRIES-1-i, so the walk meets entries in index order
    pism_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_head   (w_chain[pism_pkg::ENTRIES]),
        .o_busy   (busy),
        .o_shift  (w_shift),
        .o_entry  (w_chain[0]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    for (genvar k = 0; k < pism_pkg::ENTRIES; k++) begin : g_cell
        pism_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry (w_chain[k]),
            .o_entry (w_chain[k+1])
        );
    end

endmodule
